// ===== src/sphere_box_collision_test_macros.svh =====
// assertion helpers used by the sphere/box collision test
`ifndef SPHERE_BOX_COLLISION_TEST_MACROS_SVH
`define SPHERE_BOX_COLLISION_TEST_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define SBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication, sampled on clk_i, off during reset
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and constants of the sphere/box collision test: item formats and
// the geometry record that travels down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int COORD_W   = 24;
  localparam int RAD_W     = COORD_W - 2;
  localparam int SQ_W      = 2 * RAD_W;
  localparam int EXT_W     = COORD_W + 3;
  localparam int NUM_W     = SQ_W + 1;
  localparam int NORM_W    = 16;
  localparam int NORM_FRAC = 14;
  localparam int AXES      = 3;
  localparam int LANES     = 2 * AXES;

  localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << NORM_FRAC);

  // one query
  typedef struct packed {
    logic signed [COORD_W-1:0] sphere_x;
    logic signed [COORD_W-1:0] sphere_y;
    logic signed [COORD_W-1:0] sphere_z;
    logic        [RAD_W-1:0]   sphere_radius;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic signed [COORD_W-1:0] box_z;
    logic        [RAD_W-1:0]   half_x;
    logic        [RAD_W-1:0]   half_y;
    logic        [RAD_W-1:0]   half_z;
  } in_item_t;

  // one answer
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] box_point_x;
    logic signed [COORD_W-1:0] box_point_y;
    logic signed [COORD_W-1:0] box_point_z;
    logic signed [COORD_W-1:0] ball_point_x;
    logic signed [COORD_W-1:0] ball_point_y;
    logic signed [COORD_W-1:0] ball_point_z;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic        [RAD_W-1:0]   depth;
  } out_item_t;

  // per-query geometry carried alongside the arithmetic
  typedef struct packed {
    logic                             hit;
    logic [AXES-1:0]                  neg;
    logic [AXES-1:0][COORD_W-1:0]     s;
    logic [AXES-1:0][COORD_W-1:0]     p;
    logic [AXES-1:0][RAD_W-1:0]       a;
    logic [RAD_W-1:0]                 r;
  } geo_t;

  // sideband of the divider stages
  typedef struct packed {
    geo_t             geo;
    logic [RAD_W-1:0] root;
  } div_side_t;

endpackage

`default_nettype wire

// ===== src/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front
// Clamp of the sphere centre into the box, squares, squared distance and
// the hit compare, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  sbc_pkg::in_item_t        item_i,
  output logic                     valid_o,
  output logic [sbc_pkg::SQ_W-1:0] dist2_o,
  output sbc_pkg::geo_t            geo_o
);
  import sbc_pkg::*;

  logic signed [COORD_W-1:0]   s_in [AXES];
  logic signed [COORD_W-1:0]   c_in [AXES];
  logic        [RAD_W-1:0]     h_in [AXES];
  logic signed [EXT_W-1:0]     sx [AXES];
  logic signed [EXT_W-1:0]     lo [AXES];
  logic signed [EXT_W-1:0]     hi [AXES];
  logic signed [EXT_W-1:0]     pc [AXES];
  logic signed [EXT_W-1:0]     dv [AXES];
  logic        [EXT_W-1:0]     av [AXES];
  logic        [AXES-1:0]      near;
  geo_t                        geo1_d, geo1_q, geo2_q, geo3_q, geo4_d, geo4_q;
  logic [AXES-1:0][SQ_W-1:0]   sq_d;
  logic [AXES-1:0][SQ_W-1:0]   sq_q;
  logic [SQ_W-1:0]             rr_d, rr_q, rr3_q;
  logic [SQ_W+1:0]             sum_q;
  logic [SQ_W-1:0]             dist2_q;
  logic [3:0]                  valid_q;

  assign s_in[0] = item_i.sphere_x;
  assign s_in[1] = item_i.sphere_y;
  assign s_in[2] = item_i.sphere_z;
  assign c_in[0] = item_i.box_x;
  assign c_in[1] = item_i.box_y;
  assign c_in[2] = item_i.box_z;
  assign h_in[0] = item_i.half_x;
  assign h_in[1] = item_i.half_y;
  assign h_in[2] = item_i.half_z;

  // stage 1: clamp per axis, offset magnitude, near test (hit means near here)
  always_comb begin
    geo1_d     = '0;
    geo1_d.r   = item_i.sphere_radius;
    geo1_d.hit = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      sx[i] = EXT_W'(s_in[i]);
      lo[i] = EXT_W'(c_in[i]) - $signed(EXT_W'(h_in[i]));
      hi[i] = EXT_W'(c_in[i]) + $signed(EXT_W'(h_in[i]));
      pc[i] = (sx[i] < lo[i]) ? lo[i] : ((sx[i] > hi[i]) ? hi[i] : sx[i]);
      dv[i] = pc[i] - sx[i];
      av[i] = dv[i][EXT_W-1] ? EXT_W'(-dv[i]) : EXT_W'(dv[i]);
      near[i] = av[i] < EXT_W'(item_i.sphere_radius);
      geo1_d.s[i]   = s_in[i];
      geo1_d.p[i]   = pc[i][COORD_W-1:0];
      geo1_d.neg[i] = dv[i][EXT_W-1];
      geo1_d.a[i]   = av[i][RAD_W-1:0];
      geo1_d.hit    = geo1_d.hit & near[i];
    end
  end

  // stage 2: squares
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sq_d[i] = geo1_q.a[i] * geo1_q.a[i];
    end
    rr_d = geo1_q.r * geo1_q.r;
  end

  // stage 4: squared distance against squared radius
  always_comb begin
    geo4_d     = geo3_q;
    geo4_d.hit = geo3_q.hit && (sum_q < (SQ_W+2)'(rr3_q));
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo1_q  <= geo1_d;
      sq_q    <= sq_d;
      rr_q    <= rr_d;
      geo2_q  <= geo1_q;
      sum_q   <= (SQ_W+2)'(sq_q[0]) + (SQ_W+2)'(sq_q[1]) + (SQ_W+2)'(sq_q[2]);
      rr3_q   <= rr_q;
      geo3_q  <= geo2_q;
      geo4_q  <= geo4_d;
      dist2_q <= sum_q[SQ_W-1:0];
    end
  end

  assign valid_o = valid_q[3];
  assign dist2_o = dist2_q;
  assign geo_o   = geo4_q;

endmodule

`default_nettype wire

// ===== src/sbc_isqrt.sv =====
// ----------------------------------------------------------------------------
// sbc_isqrt
// Pipelined integer square root, one root bit per register stage, with a
// sideband record that moves in step.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_isqrt #(
  parameter type side_t = logic
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [sbc_pkg::SQ_W-1:0]  rad_i,
  input  side_t                     side_i,
  output logic                      valid_o,
  output logic [sbc_pkg::RAD_W-1:0] root_o,
  output side_t                     side_o
);
  import sbc_pkg::*;

  localparam int REM_W = SQ_W + 1;

  logic             valid_q [RAD_W];
  logic [REM_W-1:0] rem_q   [RAD_W];
  logic [RAD_W-1:0] root_q  [RAD_W];
  side_t            side_q  [RAD_W];

  for (genvar k = 0; k < RAD_W; k++) begin : g_stage
    localparam int B = RAD_W - 1 - k;
    logic             valid_in;
    logic [REM_W-1:0] rem_in, trial, rem_d;
    logic [RAD_W-1:0] root_in, root_d;
    side_t            side_in;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = REM_W'(rad_i);
      assign root_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign side_in  = side_q[k-1];
    end

    // try setting root bit B: (root + 2^B)^2 - root^2
    assign trial = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (RAD_W'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RAD_W-1];
  assign root_o  = root_q[RAD_W-1];
  assign side_o  = side_q[RAD_W-1];

endmodule

`default_nettype wire

// ===== src/sbc_div.sv =====
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider over several lanes that share one divisor,
// one quotient bit per register stage, with a sideband record.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div #(
  parameter type side_t = logic
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               en_i,
  input  logic                                               valid_i,
  input  logic [sbc_pkg::LANES-1:0][sbc_pkg::NUM_W-1:0]      num_i,
  input  logic [sbc_pkg::RAD_W-1:0]                          den_i,
  input  side_t                                              side_i,
  output logic                                               valid_o,
  output logic [sbc_pkg::LANES-1:0][sbc_pkg::RAD_W-1:0]      quo_o,
  output side_t                                              side_o
);
  import sbc_pkg::*;

  logic                             valid_q [RAD_W];
  logic [LANES-1:0][NUM_W-1:0]      rem_q   [RAD_W];
  logic [LANES-1:0][RAD_W-1:0]      quo_q   [RAD_W];
  logic [RAD_W-1:0]                 den_q   [RAD_W];
  side_t                            side_q  [RAD_W];

  for (genvar k = 0; k < RAD_W; k++) begin : g_stage
    localparam int B = RAD_W - 1 - k;
    logic                        valid_in;
    logic [LANES-1:0][NUM_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][RAD_W-1:0] quo_in, quo_d;
    logic [RAD_W-1:0]            den_in;
    logic [NUM_W-1:0]            trial;
    side_t                       side_in;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = num_i;
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign den_in   = den_q[k-1];
      assign side_in  = side_q[k-1];
    end

    assign trial = NUM_W'(den_in) << B;

    // compare and subtract in each lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= trial) begin
          rem_d[l] = rem_in[l] - trial;
          quo_d[l] = quo_in[l] | (RAD_W'(1) << B);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RAD_W-1];
  assign quo_o   = quo_q[RAD_W-1];
  assign side_o  = side_q[RAD_W-1];

endmodule

`default_nettype wire

// ===== src/sphere_box_collision_test.sv =====
// ----------------------------------------------------------------------------
// sphere_box_collision_test
// Sphere against axis-aligned box test in Q12.12 with contact points,
// unit normal and penetration depth.
// ----------------------------------------------------------------------------
// One query is taken every clock cycle while in_stall_o is low. A query passes
// through four stages of clamp, squares and compare, a 22-stage square root,
// one stage of multiplies and a 22-stage divider (one quotient bit per stage),
// after which the answer is written into a two-entry output queue. A waiting
// answer in that queue does not hold back the input; in_stall_o rises only
// while the queue is full and the last stage holds an answer.
`default_nettype none
`include "sphere_box_collision_test_macros.svh"

module sphere_box_collision_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbc_pkg::out_item_t  out_item_o
);
  import sbc_pkg::*;

  localparam int                         FIFO_DEPTH = 2;
  localparam logic [1:0]                 FIFO_FULL  = 2'(FIFO_DEPTH);
  localparam logic signed [COORD_W+1:0]  B_MAX      = (COORD_W+2)'(2**(COORD_W-1) - 1);
  localparam logic signed [COORD_W+1:0]  B_MIN      = -B_MAX - (COORD_W+2)'(1);

  logic                          en;
  logic                          fr_valid;
  logic [SQ_W-1:0]               fr_dist2;
  geo_t                          fr_geo;
  logic                          sq_valid;
  logic [RAD_W-1:0]              sq_root;
  geo_t                          sq_geo;
  logic [NUM_W-1:0]              half;
  logic [AXES-1:0][SQ_W-1:0]     prod;
  logic [LANES-1:0][NUM_W-1:0]   num_d, num_q;
  logic                          mul_valid_q;
  div_side_t                     mul_side_q;
  logic                          dv_valid;
  logic [LANES-1:0][RAD_W-1:0]   dv_quo;
  div_side_t                     dv_side;
  logic signed [COORD_W+1:0]     sx [AXES];
  logic signed [COORD_W+1:0]     qx [AXES];
  logic signed [COORD_W+1:0]     bsum [AXES];
  logic [COORD_W-1:0]            bsat [AXES];
  logic [NORM_W-1:0]             nm [AXES];
  logic [NORM_W-1:0]             nrm [AXES];
  logic                          nz;
  out_item_t                     res;
  out_item_t                     fifo_q [FIFO_DEPTH];
  logic                          wr_ptr_q, rd_ptr_q;
  logic [1:0]                    cnt_q;
  logic                          push, pop;

  // whole pipeline moves unless its last answer has nowhere to go
  assign en         = !(dv_valid && (cnt_q == FIFO_FULL));
  assign in_stall_o = !en;

  sbc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (fr_valid),
    .dist2_o (fr_dist2),
    .geo_o   (fr_geo)
  );

  sbc_isqrt #(
    .side_t (geo_t)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_dist2),
    .side_i  (fr_geo),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_geo)
  );

  // dividends with half the divisor added for rounding
  always_comb begin
    half = NUM_W'(sq_root >> 1);
    for (int i = 0; i < AXES; i++) begin
      prod[i]         = sq_geo.a[i] * sq_geo.r;
      num_d[i]        = NUM_W'(prod[i]) + half;
      num_d[AXES + i] = NUM_W'({sq_geo.a[i], NORM_FRAC'(0)}) + half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q           <= num_d;
      mul_side_q.geo  <= sq_geo;
      mul_side_q.root <= sq_root;
    end
  end

  sbc_div #(
    .side_t (div_side_t)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mul_valid_q),
    .num_i   (num_q),
    .den_i   (mul_side_q.root),
    .side_i  (mul_side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // surface point, normal and depth; centre inside the box gives zero normal
  always_comb begin
    nz = dv_side.root != '0;
    for (int i = 0; i < AXES; i++) begin
      sx[i]   = (COORD_W+2)'($signed(dv_side.geo.s[i]));
      qx[i]   = $signed((COORD_W+2)'(dv_quo[i]));
      if (!nz) begin
        bsum[i] = sx[i];
      end else if (dv_side.geo.neg[i]) begin
        bsum[i] = sx[i] - qx[i];
      end else begin
        bsum[i] = sx[i] + qx[i];
      end
      if (bsum[i] > B_MAX) begin
        bsat[i] = B_MAX[COORD_W-1:0];
      end else if (bsum[i] < B_MIN) begin
        bsat[i] = B_MIN[COORD_W-1:0];
      end else begin
        bsat[i] = bsum[i][COORD_W-1:0];
      end
      nm[i] = dv_quo[AXES + i][NORM_W-1:0];
      if (!nz) begin
        nrm[i] = '0;
      end else if (dv_side.geo.neg[i]) begin
        nrm[i] = -nm[i];
      end else begin
        nrm[i] = nm[i];
      end
    end
    res              = '0;
    res.hit          = 1'b1;
    res.box_point_x  = dv_side.geo.p[0];
    res.box_point_y  = dv_side.geo.p[1];
    res.box_point_z  = dv_side.geo.p[2];
    res.ball_point_x = bsat[0];
    res.ball_point_y = bsat[1];
    res.ball_point_z = bsat[2];
    res.normal_x     = nrm[0];
    res.normal_y     = nrm[1];
    res.normal_z     = nrm[2];
    res.depth        = dv_side.geo.r - dv_side.root;
    if (!dv_side.geo.hit) begin
      res = '0;
    end
  end

  // output queue
  assign push        = dv_valid && en;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // checks
  `SBC_ASSERT(a_cnt_range, cnt_q <= FIFO_FULL, "output queue count out of range")
  `SBC_ASSERT(a_cnt_step, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 2'd1) || (cnt_q == $past(cnt_q) - 2'd1), "output queue count jumped")
  `SBC_ASSERT_IMP(a_miss_zero, out_valid_o && !out_item_o.hit, (out_item_o.depth == '0) && (out_item_o.normal_x == '0) && (out_item_o.ball_point_x == '0) && (out_item_o.box_point_x == '0), "miss with nonzero fields")
  `SBC_ASSERT_IMP(a_norm_range, out_valid_o, (out_item_o.normal_x <= NORM_ONE) && (out_item_o.normal_x >= -NORM_ONE) && (out_item_o.normal_z <= NORM_ONE) && (out_item_o.normal_z >= -NORM_ONE), "normal beyond unit length")

endmodule

`default_nettype wire

// ===== sim/sbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_checker
// Watches both channels of the sphere/box collision test, works out the
// contact answer of every accepted query and compares it field by field
// with the answers that leave the block, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sbc_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sbc_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import sbc_pkg::*;

  out_item_t answers_due[$];

  // floor of the square root, one result bit at a time
  function automatic longint root_floor(longint v);
    longint res;
    longint cand;
    res = 0;
    for (int k = 23; k >= 0; k--) begin
      cand = res | (longint'(1) << k);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // contact answer of one query
  function automatic out_item_t contact_of(in_item_t q);
    longint    ctr[3], cen[3], hf[3], pt[3], d[3], a[3];
    longint    r, dist2, rt, b, qv, nm, lo, hi, cmax, cmin;
    bit        near;
    out_item_t o;
    o = '0;
    r = longint'(q.sphere_radius);
    ctr[0] = longint'(q.sphere_x);
    ctr[1] = longint'(q.sphere_y);
    ctr[2] = longint'(q.sphere_z);
    cen[0] = longint'(q.box_x);
    cen[1] = longint'(q.box_y);
    cen[2] = longint'(q.box_z);
    hf[0] = longint'(q.half_x);
    hf[1] = longint'(q.half_y);
    hf[2] = longint'(q.half_z);
    cmax = (longint'(1) << (COORD_W - 1)) - 1;
    cmin = -cmax - 1;
    near = 1'b1;
    // clamp the centre into the box
    for (int i = 0; i < 3; i++) begin
      lo = cen[i] - hf[i];
      hi = cen[i] + hf[i];
      pt[i] = ctr[i] < lo ? lo : (ctr[i] > hi ? hi : ctr[i]);
      d[i] = pt[i] - ctr[i];
      a[i] = d[i] < 0 ? -d[i] : d[i];
      if (a[i] >= r) near = 1'b0;
    end
    if (!near) return o;
    dist2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    if (!(dist2 < r * r)) return o;
    rt = root_floor(dist2);
    o.hit = 1'b1;
    o.depth = RAD_W'(r - rt);
    for (int i = 0; i < 3; i++) begin
      b = ctr[i];
      nm = 0;
      // centre inside the box leaves normal zero and surface point at centre
      if (rt != 0) begin
        qv = (a[i] * r + rt / 2) / rt;
        nm = (a[i] * (longint'(1) << NORM_FRAC) + rt / 2) / rt;
        b = d[i] < 0 ? ctr[i] - qv : ctr[i] + qv;
        if (d[i] < 0) nm = -nm;
      end
      if (b > cmax) b = cmax;
      if (b < cmin) b = cmin;
      case (i)
        0: begin
          o.box_point_x = COORD_W'(pt[i]);
          o.ball_point_x = COORD_W'(b);
          o.normal_x = NORM_W'(nm);
        end
        1: begin
          o.box_point_y = COORD_W'(pt[i]);
          o.ball_point_y = COORD_W'(b);
          o.normal_y = NORM_W'(nm);
        end
        default: begin
          o.box_point_z = COORD_W'(pt[i]);
          o.ball_point_z = COORD_W'(b);
          o.normal_z = NORM_W'(nm);
        end
      endcase
    end
    return o;
  endfunction

  function automatic int field_check(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // queries in, answers out
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        bad;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
      answers_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $error("answer with no query waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answers_due.pop_front();
          bad = 0;
          bad += field_check("hit", want.hit, out_item_i.hit);
          bad += field_check("box_point_x", want.box_point_x, out_item_i.box_point_x);
          bad += field_check("box_point_y", want.box_point_y, out_item_i.box_point_y);
          bad += field_check("box_point_z", want.box_point_z, out_item_i.box_point_z);
          bad += field_check("ball_point_x", want.ball_point_x, out_item_i.ball_point_x);
          bad += field_check("ball_point_y", want.ball_point_y, out_item_i.ball_point_y);
          bad += field_check("ball_point_z", want.ball_point_z, out_item_i.ball_point_z);
          bad += field_check("normal_x", want.normal_x, out_item_i.normal_x);
          bad += field_check("normal_y", want.normal_y, out_item_i.normal_y);
          bad += field_check("normal_z", want.normal_z, out_item_i.normal_z);
          bad += field_check("depth", want.depth, out_item_i.depth);
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i) answers_due.push_back(contact_of(in_item_i));
      pending_o <= answers_due.size();
    end
  end

  final begin
    if (answers_due.size() != 0) $error("%0d answers never arrived", answers_due.size());
  end

endmodule

`default_nettype wire

// ===== sim/sphere_box_collision_test_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_box_collision_test_test
// Drives directed and random sphere/box queries into the collision test,
// with random idling on both sides and a long output hold-off, and reports
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_box_collision_test_test;
  import sbc_pkg::*;

  localparam int N_RANDOM    = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 120;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles = 0;

  sphere_box_collision_test uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sbc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, a few long
  function automatic int gap_len(bit busy);
    int pick;
    pick = $urandom_range(0, 99);
    if (busy || pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, one long hold-off early on
  initial begin
    bit busy;
    int g;
    @(posedge rst_ni);
    repeat (300) @(posedge clk_i);
    out_stall <= 1'b1;
    repeat (400) @(posedge clk_i);
    out_stall <= 1'b0;
    forever begin
      busy = $urandom_range(0, 3) == 0;
      repeat ($urandom_range(20, 120)) begin
        g = gap_len(busy);
        if (g != 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk_i);
          out_stall <= 1'b0;
        end
        @(posedge clk_i);
      end
    end
  end

  task automatic send_query(in_item_t q, int gap);
    in_valid <= 1'b1;
    in_item <= q;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t make_query(longint sx, longint sy, longint sz, longint r,
                                          longint bx, longint by, longint bz,
                                          longint hx, longint hy, longint hz);
    in_item_t q;
    q.sphere_x = COORD_W'(sx);
    q.sphere_y = COORD_W'(sy);
    q.sphere_z = COORD_W'(sz);
    q.sphere_radius = RAD_W'(r);
    q.box_x = COORD_W'(bx);
    q.box_y = COORD_W'(by);
    q.box_z = COORD_W'(bz);
    q.half_x = RAD_W'(hx);
    q.half_y = RAD_W'(hy);
    q.half_z = RAD_W'(hz);
    return q;
  endfunction

  // random query, mostly placed so that sphere and box are close
  function automatic in_item_t random_query();
    in_item_t q;
    longint   sc, r, off;
    int       sh;
    q = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom});
    if ($urandom_range(0, 4) == 0) return q;
    sh = $urandom_range(0, 20);
    q.sphere_radius = RAD_W'(longint'($urandom_range(1, 32'h3fffff)) >> sh);
    if (q.sphere_radius == 0) q.sphere_radius = 1;
    q.half_x = RAD_W'(longint'($urandom_range(0, 32'h3fffff)) >> $urandom_range(0, 21));
    q.half_y = RAD_W'(longint'($urandom_range(0, 32'h3fffff)) >> $urandom_range(0, 21));
    q.half_z = RAD_W'(longint'($urandom_range(0, 32'h3fffff)) >> $urandom_range(0, 21));
    r = longint'(q.sphere_radius);
    sc = r + longint'(q.half_x);
    off = longint'($urandom_range(0, 2 * sc)) - sc;
    q.sphere_x = COORD_W'(longint'(q.box_x) + off);
    sc = r + longint'(q.half_y);
    off = longint'($urandom_range(0, 2 * sc)) - sc;
    q.sphere_y = COORD_W'(longint'(q.box_y) + off);
    sc = r + longint'(q.half_z);
    off = longint'($urandom_range(0, 2 * sc)) - sc;
    q.sphere_z = COORD_W'(longint'(q.box_z) + off);
    return q;
  endfunction

  initial begin
    in_item_t dir_q[$];
    longint   cmx, cmn, rmx;
    bit       busy;
    cmx = (longint'(1) << (COORD_W - 1)) - 1;
    cmn = -cmx - 1;
    rmx = (longint'(1) << RAD_W) - 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero radius, centre inside the box
    dir_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 100, 100, 100));
    dir_q.push_back(make_query(10, -20, 30, 5000, 0, 0, 0, 100, 100, 100));
    // far on one axis only
    dir_q.push_back(make_query(0, 0, 0, 1000, 1000, 0, 0, 0, 0, 0));
    // squared distance exactly the squared radius, then just inside
    dir_q.push_back(make_query(0, 0, 0, 5000, 3000, 4000, 0, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 5001, 3000, 4000, 0, 0, 0, 0));
    // normals along single axes, both signs, and one along the diagonal
    dir_q.push_back(make_query(0, 0, 0, 4096, 2048, 0, 0, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 4096, 0, -2048, 0, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 4096, 0, 0, -1, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 4096, 1, 1, 1, 0, 0, 0));
    // surface point saturation at both ends
    dir_q.push_back(make_query(cmx - 10, cmx - 10, cmx - 10, rmx, cmx, cmx, cmx, 5, 5, 5));
    dir_q.push_back(make_query(cmn + 10, cmn + 10, cmn + 10, rmx, cmn, cmn, cmn, 5, 5, 5));
    // largest sizes
    dir_q.push_back(make_query(cmx, cmn, cmx, rmx, cmn, cmx, cmn, rmx, rmx, rmx));
    dir_q.push_back(make_query(cmn, cmn, cmn, rmx, cmn + rmx + 3000000, cmn, cmn, rmx, 0, 0));
    dir_q.push_back(make_query(cmx, cmx, cmx, rmx, cmx, cmx, cmx, rmx, rmx, rmx));
    dir_q.push_back(make_query(-1, -1, -1, rmx, -1 - rmx, 1 + rmx, 0, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(make_query(0, 0, 0, 2, 1, 0, 0, 0, 0, 0));
    dir_q.push_back(make_query(-7, 9, -11, 3, -8, 10, -12, 0, 0, 0));
    foreach (dir_q[i]) send_query(dir_q[i], $urandom_range(0, 1));

    // random queries in stretches, one pause until all answers are back
    busy = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) busy = $urandom_range(0, 2) == 0;
      if (n == 700) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_query(random_query(), gap_len(busy));
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
